// File: sv/vdt_pkg.sv
// Shared constants and types for the vertex deduplication table.
// No dependencies; compiled first.
`default_nettype none

package vdt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH  = 1024;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W    = 10;

    // One vertex: eight IEEE single words, word 0 is pos_x, word 7 is tex_v
    localparam int VERTEX_WORDS = 8;
    localparam int WORD_W       = 32;
    localparam int ENTRY_W      = VERTEX_WORDS * WORD_W;

    typedef logic [WORD_W-1:0]                   t_word;
    typedef logic [VERTEX_WORDS-1:0][WORD_W-1:0] t_vertex;
    typedef logic [CNT_W-1:0]                    t_count;
    typedef logic [OUT_IDX_W-1:0]                t_out_idx;

    // Low OUT_IDX_W bits of a table index, zero-extended if the table is small
    function automatic t_out_idx to_out_idx(input t_count idx);
        logic [CNT_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/vdt_if.sv
// Channel interfaces: vertex input beats and index result beats.
// Depends on vdt_pkg.
`default_nettype none

interface vdt_vtx_if;
    import vdt_pkg::*;

    logic  valid;
    logic  ready;
    t_word pos_x;
    t_word pos_y;
    t_word pos_z;
    t_word norm_x;
    t_word norm_y;
    t_word norm_z;
    t_word tex_u;
    t_word tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, output ready);
endinterface

interface vdt_res_if;
    import vdt_pkg::*;

    logic     valid;
    logic     ready;
    t_out_idx vertex_index;
    logic     was_added;
    logic     table_full;

    modport source (output valid, vertex_index, was_added, table_full, input ready);
    modport sink   (input valid, vertex_index, was_added, table_full, output ready);
endinterface

`default_nettype wire

// File: sv/vdt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependency.
`default_nettype none

module vdt_ram #(
    parameter int DATA_W = 256,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered: data in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/vdt_cmp.sv
// Entry compare unit: IEEE equality of all eight words of a stored entry
// against the search key. Depends on vdt_pkg.
`default_nettype none

module vdt_cmp (
    input  wire vdt_pkg::t_vertex i_entry,
    input  wire vdt_pkg::t_vertex i_key,
    output logic                  o_match
);
    import vdt_pkg::*;

    localparam t_word MAG_MASK = 32'h7FFF_FFFF;
    localparam t_word INF_BITS = 32'h7F80_0000;

    // +0 equals -0, a NaN equals nothing
    function automatic logic word_eq(input t_word a, input t_word b);
        logic a_nan;
        logic b_nan;
        logic zeros;
        a_nan = (a & MAG_MASK) > INF_BITS;
        b_nan = (b & MAG_MASK) > INF_BITS;
        zeros = ((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0);
        return !a_nan && !b_nan && ((a == b) || zeros);
    endfunction

    logic [VERTEX_WORDS-1:0] w_word_eq;

    // eight independent word compares, then AND
    always_comb begin
        for (int j = 0; j < VERTEX_WORDS; j++) begin
            w_word_eq[j] = word_eq(i_entry[j], i_key[j]);
        end
    end

    assign o_match = &w_word_eq;

endmodule

`default_nettype wire

// File: sv/vertex_dedup_table.sv
// Vertex deduplication table: find-or-insert over a stored vertex list.
// Depends on vdt_pkg, vdt_if, vdt_ram and vdt_cmp.
//
// Usage:
//   i_vtx carries one vertex per beat (eight IEEE single words). o_res returns
//   exactly one beat per vertex: the index of the first stored entry that is
//   IEEE-equal in all eight words, or the index of the newly appended entry
//   (was_added = 1). With no match and a full table, table_full = 1, the
//   index is zero and nothing is stored.
//   The search reads one entry per cycle from the vertex RAM read port into a
//   single shared compare unit, so one vertex is handled at a time and i_vtx
//   is not ready while a search runs.
//   The result sits in an output register; the next vertex is accepted while
//   it waits. If the receiver stalls, a finished search holds until the
//   output register frees, and input stays not ready.
//   Reset clears the entry count and the control state. The vertex RAM is not
//   cleared; entries at or above the count are never read, so no clearing
//   pass is needed.
`default_nettype none

module vertex_dedup_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vdt_vtx_if.sink    i_vtx,
    vdt_res_if.source  o_res
);
    import vdt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state   r_state;
    t_vertex  r_key;
    t_count   r_count;
    t_count   r_addr;
    logic     r_pend;
    t_count   r_pend_idx;
    t_count   r_res_idx;
    logic     r_res_added;
    logic     r_res_full;
    logic     r_out_vld;
    t_out_idx r_out_idx;
    logic     r_out_added;
    logic     r_out_full;

    t_vertex  w_rdata;
    logic     w_match;
    logic     w_issue;
    logic     w_hit;
    logic     w_miss;
    logic     w_full;
    logic     w_we;
    logic     w_accept;
    logic     w_load;

    // search control
    assign w_accept = i_vtx.valid && i_vtx.ready;
    assign w_issue  = (r_state == S_SCAN) && (r_addr < r_count);
    assign w_hit    = (r_state == S_SCAN) && r_pend && w_match;
    assign w_miss   = (r_state == S_SCAN) && !r_pend && (r_addr >= r_count);
    assign w_full   = r_count == CNT_W'(TABLE_DEPTH);
    assign w_we     = w_miss && !w_full;

    // result moves into the output register when it is free or draining
    assign w_load   = (r_state == S_RESP) && (!r_out_vld || o_res.ready);

    // vertex storage
    vdt_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_key),
        .i_re    (w_issue),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // shared compare unit
    vdt_cmp u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_key),
        .o_match (w_match)
    );

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key   <= {i_vtx.tex_v, i_vtx.tex_u, i_vtx.norm_z, i_vtx.norm_y,
                                    i_vtx.norm_x, i_vtx.pos_z, i_vtx.pos_y, i_vtx.pos_x};
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_res_idx   <= r_pend_idx;
                        r_res_added <= 1'b0;
                        r_res_full  <= 1'b0;
                        r_state     <= S_RESP;
                    end else if (w_miss) begin
                        if (w_full) begin
                            r_res_idx   <= '0;
                            r_res_added <= 1'b0;
                            r_res_full  <= 1'b1;
                        end else begin
                            r_res_idx   <= r_count;
                            r_res_added <= 1'b1;
                            r_res_full  <= 1'b0;
                            r_count     <= r_count + 1'b1;
                        end
                        r_state <= S_RESP;
                    end else begin
                        // entry read this cycle is compared next cycle
                        r_pend     <= w_issue;
                        r_pend_idx <= r_addr;
                        if (w_issue) begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                end
                S_RESP: begin
                    if (w_load) begin
                        r_out_idx   <= to_out_idx(r_res_idx);
                        r_out_added <= r_res_added;
                        r_out_full  <= r_res_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_vtx.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_vld;
    assign o_res.vertex_index = r_out_idx;
    assign o_res.was_added    = r_out_added;
    assign o_res.table_full   = r_out_full;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> (r_pend_idx < r_count))
        else $error("compared entry lies beyond stored entries");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance entry count");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_added && r_out_full))
        else $error("result both added and full");

    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_full) |-> (r_out_idx == '0))
        else $error("full result carries nonzero index");

endmodule

`default_nettype wire
